[sv/smm_pkg.sv]
// shared types, codes and constants of the small matrix multiply block
package smm_pkg;

	localparam int MaxDimDefault = 8;
	localparam int DimW          = 4;
	localparam int ValW          = 32;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_START  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_ROWS_A    = 2'd0,
		CFG_INNER_DIM = 2'd1,
		CFG_COLS_B    = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [2:0]             elem_row;
		logic [2:0]             elem_col;
		logic signed [ValW-1:0] elem_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]             out_row;
		logic [2:0]             out_col;
		logic signed [ValW-1:0] product_value;
		logic                   last_result;
	} out_item_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last_k;
		logic       zero;
		logic       last;
		logic [2:0] row;
		logic [2:0] col;
	} step_t;

	typedef struct packed {
		logic [DimW-1:0] rows_a;
		logic [DimW-1:0] inner_dim;
		logic [DimW-1:0] cols_b;
	} dims_t;

endpackage

[sv/smm_mem.sv]
// single-port-write, single-port-read synchronous element store
module smm_mem
	import smm_pkg::*;
#(
	parameter int Depth = MaxDimDefault * MaxDimDefault,
	parameter int AddrW = $clog2(Depth)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AddrW-1:0] waddr,
	input  logic [ValW-1:0] wdata,
	input  logic            re,
	input  logic [AddrW-1:0] raddr,
	output logic [ValW-1:0] rdata
);

	logic [ValW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/smm_ctrl.sv]
// command decode, store writes and multiply sequencer
module smm_ctrl
	import smm_pkg::*;
#(
	parameter int MaxDim = MaxDimDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  in_item_t                         in_data,
	input  dims_t                            dims,
	input  logic                             adv,
	output logic                             we_a,
	output logic                             we_b,
	output logic [$clog2(MaxDim*MaxDim)-1:0] waddr,
	output logic [ValW-1:0]                  wdata,
	output logic [$clog2(MaxDim*MaxDim)-1:0] raddr_a,
	output logic [$clog2(MaxDim*MaxDim)-1:0] raddr_b,
	output step_t                            step_s1
);

	localparam int AddrW = $clog2(MaxDim * MaxDim);
	localparam int IdxW  = $clog2(MaxDim);
	localparam int CntW  = $clog2(MaxDim + 1);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t          state_q;
	logic [IdxW-1:0] i_q, j_q, k_q;
	logic [CntW-1:0] nr, nk, nc;
	logic [CntW-1:0] nr_m1, nk_m1, nc_m1;
	logic            accept, load_ok, issue;
	logic            last_k, last_j, last_i;
	step_t           step;

	function automatic logic [CntW-1:0] clamp_dim(input logic [DimW-1:0] v);
		return (32'(v) > MaxDim) ? CntW'(MaxDim) : CntW'(v);
	endfunction

	always_comb begin
		nr    = clamp_dim(dims.rows_a);
		nk    = clamp_dim(dims.inner_dim);
		nc    = clamp_dim(dims.cols_b);
		nr_m1 = nr - CntW'(1);
		nk_m1 = (nk == '0) ? '0 : nk - CntW'(1);
		nc_m1 = nc - CntW'(1);

		in_stall = (state_q != ST_IDLE);
		accept   = in_valid && !in_stall;
		load_ok  = (32'(in_data.elem_row) < MaxDim) && (32'(in_data.elem_col) < MaxDim);
		we_a     = accept && load_ok && (in_data.cmd == CMD_LOAD_A);
		we_b     = accept && load_ok && (in_data.cmd == CMD_LOAD_B);
		waddr    = AddrW'(AddrW'(in_data.elem_row) * AddrW'(MaxDim)) + AddrW'(in_data.elem_col);
		wdata    = in_data.elem_value;

		raddr_a  = AddrW'(AddrW'(i_q) * AddrW'(MaxDim)) + AddrW'(k_q);
		raddr_b  = AddrW'(AddrW'(k_q) * AddrW'(MaxDim)) + AddrW'(j_q);

		issue    = (state_q == ST_RUN) && adv;
		last_k   = (CntW'(k_q) == nk_m1);
		last_j   = (CntW'(j_q) == nc_m1);
		last_i   = (CntW'(i_q) == nr_m1);

		step.valid  = issue;
		step.first  = (k_q == '0);
		step.last_k = last_k;
		step.zero   = (nk == '0);
		step.last   = last_k && last_j && last_i;
		step.row    = 3'(i_q);
		step.col    = 3'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			step_s1 <= '0;
		end else begin
			if (adv) begin
				step_s1 <= step;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_data.cmd == CMD_START && nr != '0 && nc != '0) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (last_k) begin
							k_q <= '0;
							if (last_j) begin
								j_q <= '0;
								if (last_i) begin
									i_q     <= '0;
									state_q <= ST_IDLE;
								end else begin
									i_q <= i_q + IdxW'(1);
								end
							end else begin
								j_q <= j_q + IdxW'(1);
							end
						end else begin
							k_q <= k_q + IdxW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/smm_mac.sv]
// registered multiply and wrapping accumulate of one dot product
module smm_mac
	import smm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  step_t           step_s1,
	input  logic [ValW-1:0] a_rd,
	input  logic [ValW-1:0] b_rd,
	output logic            res_valid,
	output out_item_t       res
);

	step_t           step_s2;
	logic [ValW-1:0] prod_s2;
	logic [ValW-1:0] acc_q;
	logic [ValW-1:0] sum;

	always_comb begin
		sum = (step_s2.first ? '0 : acc_q) + (step_s2.zero ? '0 : prod_s2);
		res_valid         = step_s2.valid && step_s2.last_k;
		res.out_row       = step_s2.row;
		res.out_col       = step_s2.col;
		res.product_value = sum;
		res.last_result   = step_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s2 <= '0;
		end else if (adv) begin
			step_s2 <= step_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= a_rd * b_rd;
			if (step_s2.valid) begin
				acc_q <= sum;
			end
		end
	end

endmodule

[sv/small_matrix_multiply_top.sv]
// top level of the small matrix multiply block
// Load items (cmd 0 or 1) write one element of store A or B; while the sequencer is idle,
// loads stream at one per cycle. A start item keeps the input stalled while the sequencer
// walks the product: one multiply-accumulate step per cycle unless the output stalls, set
// by the single read port of each store feeding one multiplier. A result passes the store
// read and step_s1 registers, then the product and step_s2 registers. Results leave in
// row-major order through an output register; a stalled output freezes the whole pipeline.
// Dimensions above MAX_DIM are treated as MAX_DIM; rows_a or cols_b of zero emits nothing.
module small_matrix_multiply_top
	import smm_pkg::*;
#(
	parameter int MAX_DIM = MaxDimDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  in_item_t        in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output out_item_t       out_data,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [DimW-1:0] cfg_data
);

	localparam int Depth = MAX_DIM * MAX_DIM;
	localparam int AddrW = $clog2(Depth);

	dims_t           dims_q;
	logic            adv;
	logic            we_a, we_b;
	logic [AddrW-1:0] waddr, raddr_a, raddr_b;
	logic [ValW-1:0] wdata, a_rd, b_rd;
	step_t           step_s1;
	logic            res_valid;
	out_item_t       res;
	logic            out_valid_q;
	out_item_t       out_data_q;

	assign adv       = !(out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.rows_a    <= DimW'(0);
			dims_q.inner_dim <= DimW'(1);
			dims_q.cols_b    <= DimW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS_A:    dims_q.rows_a    <= cfg_data;
				CFG_INNER_DIM: dims_q.inner_dim <= cfg_data;
				CFG_COLS_B:    dims_q.cols_b    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	smm_ctrl #(
		.MaxDim(MAX_DIM)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.dims    (dims_q),
		.adv     (adv),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.step_s1 (step_s1)
	);

	smm_mem #(
		.Depth(Depth),
		.AddrW(AddrW)
	) u_store_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.re   (adv),
		.raddr(raddr_a),
		.rdata(a_rd)
	);

	smm_mem #(
		.Depth(Depth),
		.AddrW(AddrW)
	) u_store_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.re   (adv),
		.raddr(raddr_b),
		.rdata(b_rd)
	);

	smm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.step_s1  (step_s1),
		.a_rd     (a_rd),
		.b_rd     (b_rd),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule

[verif/testbench.sv]
// self-checking testbench for the small matrix multiply block
module testbench;
	import smm_pkg::*;

	localparam int MaxDim      = MaxDimDefault;
	localparam int RandomItems = 310;
	localparam int DrainCycles = 12;

	typedef enum logic [1:0] {ROW_ITEM, ROW_DIMS} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} row_check_t;
	typedef enum logic [1:0] {STALL_OFF, STALL_LIGHT, STALL_EVERY3, STALL_HEAVY} stall_mode_t;

	typedef struct packed {
		row_kind_t  kind;
		row_check_t check;
		in_item_t   item;
		dims_t      dims;
		out_item_t  typed;
	} dir_row_t;

	localparam dims_t     NoDims = '0;
	localparam out_item_t NoOut  = '0;
	localparam int        NumDir = 25;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_stall;
	in_item_t        in_data   = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	out_item_t       out_data;
	logic            cfg_we    = 1'b0;
	logic [1:0]      cfg_index = CFG_ROWS_A;
	logic [DimW-1:0] cfg_data  = '0;

	logic [ValW-1:0] shadow_a [MaxDim*MaxDim];
	logic [ValW-1:0] shadow_b [MaxDim*MaxDim];
	bit              written_a [MaxDim*MaxDim];
	bit              written_b [MaxDim*MaxDim];
	dims_t           dims_now = '{4'd0, 4'd1, 4'd1};
	out_item_t       pending_products [$];

	int          n_items    = 0;
	int          n_starts   = 0;
	int          n_results  = 0;
	int          n_settings = 0;
	int          n_errors   = 0;
	int          burst_left = 0;
	int          stall_tick = 0;
	stall_mode_t stall_mode = STALL_OFF;

	dir_row_t dir_table [NumDir] = '{
		'{ROW_ITEM, CHK_NONE,  '{CMD_START,  3'd0, 3'd0, 32'h00000000}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_A, 3'd0, 3'd0, 32'h7fffffff}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_B, 3'd0, 3'd0, 32'h80000000}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_NONE,   3'd0, 3'd0, 32'hffffffff}, NoDims, NoOut},
		'{ROW_DIMS, CHK_MODEL, '0, '{4'd1, 4'd1, 4'd1}, NoOut},
		'{ROW_ITEM, CHK_TYPED, '{CMD_START,  3'd0, 3'd0, 32'h00000000}, NoDims,
			'{3'd0, 3'd0, 32'h80000000, 1'b1}},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_A, 3'd0, 3'd1, 32'h80000000}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_B, 3'd1, 3'd0, 32'h80000000}, NoDims, NoOut},
		'{ROW_DIMS, CHK_MODEL, '0, '{4'd1, 4'd2, 4'd1}, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_START,  3'd7, 3'd7, 32'hffffffff}, NoDims, NoOut},
		'{ROW_DIMS, CHK_MODEL, '0, '{4'd1, 4'd0, 4'd1}, NoOut},
		'{ROW_ITEM, CHK_TYPED, '{CMD_START,  3'd0, 3'd0, 32'h00000000}, NoDims,
			'{3'd0, 3'd0, 32'h00000000, 1'b1}},
		'{ROW_DIMS, CHK_MODEL, '0, '{4'd1, 4'd1, 4'd0}, NoOut},
		'{ROW_ITEM, CHK_NONE,  '{CMD_START,  3'd0, 3'd0, 32'h00000000}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_A, 3'd7, 3'd7, 32'h00000000}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_B, 3'd7, 3'd7, 32'h00000001}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_A, 3'd1, 3'd0, 32'hffffffff}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_A, 3'd1, 3'd1, 32'h00000001}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_B, 3'd0, 3'd1, 32'h00000003}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_LOAD_B, 3'd1, 3'd1, 32'hfffffffb}, NoDims, NoOut},
		'{ROW_DIMS, CHK_MODEL, '0, '{4'd2, 4'd2, 4'd2}, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_START,  3'd0, 3'd0, 32'h00000000}, NoDims, NoOut},
		'{ROW_ITEM, CHK_MODEL, '{CMD_START,  3'd5, 3'd2, 32'h12345678}, NoDims, NoOut},
		'{ROW_DIMS, CHK_MODEL, '0, '{4'd0, 4'd15, 4'd15}, NoOut},
		'{ROW_ITEM, CHK_NONE,  '{CMD_START,  3'd0, 3'd0, 32'h00000000}, NoDims, NoOut}
	};

	small_matrix_multiply_top #(.MAX_DIM(MaxDim)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int eff_dim(input logic [DimW-1:0] v);
		return (v > MaxDim) ? MaxDim : int'(v);
	endfunction

	function automatic logic [ValW-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 15)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 40)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// shadow store update or expected products for one accepted transfer
	task automatic predict_matmul(input in_item_t it);
		int nr, nk, nc;
		logic [ValW-1:0] acc;
		out_item_t res;
		nr = eff_dim(dims_now.rows_a);
		nk = eff_dim(dims_now.inner_dim);
		nc = eff_dim(dims_now.cols_b);
		case (cmd_t'(it.cmd))
			CMD_LOAD_A: begin
				shadow_a[it.elem_row*MaxDim+it.elem_col]  = it.elem_value;
				written_a[it.elem_row*MaxDim+it.elem_col] = 1'b1;
			end
			CMD_LOAD_B: begin
				shadow_b[it.elem_row*MaxDim+it.elem_col]  = it.elem_value;
				written_b[it.elem_row*MaxDim+it.elem_col] = 1'b1;
			end
			CMD_START: begin
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = '0;
						for (int k = 0; k < nk; k++)
							acc = acc + shadow_a[i*MaxDim+k] * shadow_b[k*MaxDim+j];
						res.out_row       = 3'(i);
						res.out_col       = 3'(j);
						res.product_value = acc;
						res.last_result   = (i == nr - 1) && (j == nc - 1);
						pending_products.push_back(res);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (it.cmd == CMD_START)
			n_starts++;
		if (it.cmd != CMD_NONE)
			n_items++;
	endtask

	task automatic issue(input in_item_t it);
		send_item(it);
		predict_matmul(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_products.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_dims(input dims_t d);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS_A;
		cfg_data  <= d.rows_a;
		@(posedge clk);
		cfg_index <= CFG_INNER_DIM;
		cfg_data  <= d.inner_dim;
		@(posedge clk);
		cfg_index <= CFG_COLS_B;
		cfg_data  <= d.cols_b;
		@(posedge clk);
		cfg_we   <= 1'b0;
		dims_now = d;
		n_settings++;
	endtask

	function automatic logic [DimW-1:0] pick_dim();
		case ($urandom_range(0, 11))
			0: return 4'd0;
			1: return 4'd8;
			2: return 4'd15;
			3: return 4'($urandom_range(9, 14));
			default: return 4'($urandom_range(1, 3));
		endcase
	endfunction

	// a load inside the current operands where they are not empty
	function automatic in_item_t operand_load(input bit to_b);
		int nr, nk, nc;
		in_item_t it;
		nr = eff_dim(dims_now.rows_a);
		nk = (eff_dim(dims_now.inner_dim) > 0) ? eff_dim(dims_now.inner_dim) : 1;
		nc = eff_dim(dims_now.cols_b);
		it.elem_value = rand_value();
		if (to_b) begin
			it.cmd      = CMD_LOAD_B;
			it.elem_row = 3'($urandom_range(0, nk - 1));
			it.elem_col = (nc > 0) ? 3'($urandom_range(0, nc - 1)) : 3'($urandom);
		end else begin
			it.cmd      = CMD_LOAD_A;
			it.elem_row = (nr > 0) ? 3'($urandom_range(0, nr - 1)) : 3'($urandom);
			it.elem_col = 3'($urandom_range(0, nk - 1));
		end
		return it;
	endfunction

	// no start may read an entry that was never loaded
	task automatic cover_operands();
		int nr, nk, nc;
		in_item_t it;
		nr = eff_dim(dims_now.rows_a);
		nk = (eff_dim(dims_now.inner_dim) > 0) ? eff_dim(dims_now.inner_dim) : 1;
		nc = eff_dim(dims_now.cols_b);
		if (nr == 0 || nc == 0)
			return;
		for (int i = 0; i < nr; i++) begin
			for (int k = 0; k < nk; k++) begin
				if (!written_a[i*MaxDim+k]) begin
					it = '{CMD_LOAD_A, 3'(i), 3'(k), rand_value()};
					issue(it);
				end
			end
		end
		for (int k = 0; k < nk; k++) begin
			for (int j = 0; j < nc; j++) begin
				if (!written_b[k*MaxDim+j]) begin
					it = '{CMD_LOAD_B, 3'(k), 3'(j), rand_value()};
					issue(it);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 64 == 0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_OFF:    out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
			STALL_EVERY3: out_stall <= (stall_tick % 3 == 0);
			default:      out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin : product_monitor
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_products.size() == 0) begin
				report_mismatch($sformatf("unexpected product (%0d,%0d) %h",
					out_data.out_row, out_data.out_col, out_data.product_value));
			end else begin
				want = pending_products.pop_front();
				check_field("out_row", 32'(out_data.out_row), 32'(want.out_row));
				check_field("out_col", 32'(out_data.out_col), 32'(want.out_col));
				check_field("product_value", out_data.product_value, want.product_value);
				check_field("last_result", 32'(out_data.last_result), 32'(want.last_result));
			end
		end
	end

	initial begin
		#20000000;
		$display("small_matrix_multiply_top verification failed");
		$finish;
	end

	initial begin
		dims_t    d;
		in_item_t it;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[r]) begin
			if (dir_table[r].kind == ROW_DIMS) begin
				set_dims(dir_table[r].dims);
			end else begin
				case (dir_table[r].check)
					CHK_MODEL: issue(dir_table[r].item);
					CHK_TYPED: begin
						send_item(dir_table[r].item);
						pending_products.push_back(dir_table[r].typed);
					end
					default: send_item(dir_table[r].item);
				endcase
			end
		end

		while (n_items < RandomItems) begin
			d.rows_a    = pick_dim();
			d.inner_dim = pick_dim();
			d.cols_b    = pick_dim();
			set_dims(d);
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 10)) begin
					case ($urandom_range(0, 9))
						0: it = '{CMD_NONE, 3'($urandom), 3'($urandom), $urandom};
						1, 2: it = '{cmd_t'($urandom_range(0, 1)), 3'($urandom),
							3'($urandom), rand_value()};
						default: it = operand_load($urandom_range(0, 1));
					endcase
					issue(it);
				end
				cover_operands();
				it = '{CMD_START, 3'($urandom), 3'($urandom), $urandom};
				issue(it);
			end
		end

		wait_idle();
		$display("ran %0d loads and starts (%0d starts) over %0d dimension settings",
			n_items, n_starts, n_settings);
		$display("checked %0d product elements, %0d mismatches", n_results, n_errors);
		if (n_errors == 0)
			$display("small_matrix_multiply_top verification clean");
		else
			$display("small_matrix_multiply_top verification failed");
		$finish;
	end

endmodule

[sim.f]
sv/smm_pkg.sv
sv/smm_mem.sv
sv/smm_ctrl.sv
sv/smm_mac.sv
sv/small_matrix_multiply_top.sv
verif/testbench.sv
